>>> hw/rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned ENTRY_W     = 32;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned FLAG_W      = 12;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  // flags written into every new directory and page entry
  localparam logic [FLAG_W-1:0] NEW_FLAGS = 12'h007;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_MAP    = 2'd1,
    OP_UNMAP  = 2'd2,
    OP_NOP    = 2'd3
  } tlpt_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_TABLE = 2'd1,
    ST_NO_PAGE  = 2'd2,
    ST_MAPPED   = 2'd3
  } tlpt_status_e;

  typedef struct packed {
    tlpt_op_e           op;
    logic [FRAME_W-1:0] phys_frame;
    logic [FRAME_W-1:0] table_frame;
  } tlpt_cmd_t;

endpackage

>>> hw/rtl/tlpt_if.sv
// ----------------------------------------------------------------------------
// tlpt_if
// Request and response channels of the page table engine.
// ----------------------------------------------------------------------------
interface tlpt_req_if import tlpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [ADDR_W-1:0]  vaddr;
  logic [FRAME_W-1:0] phys_frame;
  logic [FRAME_W-1:0] table_frame;

  modport source (output valid, mode, vaddr, phys_frame, table_frame, input ready);
  modport sink   (input valid, mode, vaddr, phys_frame, table_frame, output ready);
endinterface

interface tlpt_rsp_if import tlpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] phys_addr;
  logic [FLAG_W-1:0] entry_flags;

  modport source (output valid, status, phys_addr, entry_flags, input ready);
  modport sink   (input valid, status, phys_addr, entry_flags, output ready);
endinterface

>>> hw/rtl/two_level_page_table_engine_unit.sv
// a result passes through the command queue, the memory read registers and the response register
// the back end takes a new command only after the last one has finished: the directory/page
//   memory read, then the check-and-write step of the execution sequencer
// a map that creates a table also writes every entry of that table (table sweep)
// reset: a clearing pass over every directory entry, no request taken
// ----------------------------------------------------------------------------
// two_level_page_table_engine_unit
// Two-level page table with lookup, map and unmap, front end and back end
// decoupled by a short command queue.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_unit import tlpt_pkg::*; #(
  parameter int unsigned DIR_INDEX_BITS   = 10,
  parameter int unsigned TABLE_INDEX_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlpt_req_if.sink   req_i,
  tlpt_rsp_if.source rsp_o
);

  localparam int unsigned QW = DIR_INDEX_BITS + TABLE_INDEX_BITS + $bits(tlpt_cmd_t);

  logic          init_done;
  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  tlpt_front #(
    .DIR_INDEX_BITS  (DIR_INDEX_BITS),
    .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
  ) u_front (
    .req_i       (req_i),
    .init_done_i (init_done),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  tlpt_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready)
  );

  tlpt_back #(
    .DIR_INDEX_BITS  (DIR_INDEX_BITS),
    .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_data_i (pop_data),
    .pop_ready_o(pop_ready),
    .init_done_o(init_done),
    .rsp_o      (rsp_o)
  );

endmodule

>>> hw/rtl/tlpt_fifo.sv
// ----------------------------------------------------------------------------
// tlpt_fifo
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module tlpt_fifo #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front
// Accepts requests, decodes the operation and splits the address indexes.
// ----------------------------------------------------------------------------
module tlpt_front import tlpt_pkg::*; #(
  parameter int unsigned DIR_INDEX_BITS   = 10,
  parameter int unsigned TABLE_INDEX_BITS = 10,
  localparam int unsigned QW = DIR_INDEX_BITS + TABLE_INDEX_BITS + $bits(tlpt_cmd_t)
) (
  tlpt_req_if.sink        req_i,
  input  logic            init_done_i,
  output logic            push_valid_o,
  output logic [QW-1:0]   push_data_o,
  input  logic            push_ready_i
);

  logic [DIR_INDEX_BITS-1:0]   dir_idx;
  logic [TABLE_INDEX_BITS-1:0] tbl_idx;
  tlpt_cmd_t                   cmd;

  // no request while the directory is being cleared
  assign req_i.ready  = push_ready_i & init_done_i;
  assign push_valid_o = req_i.valid & init_done_i;

  assign tbl_idx = req_i.vaddr[PAGE_SHIFT +: TABLE_INDEX_BITS];
  assign dir_idx = req_i.vaddr[PAGE_SHIFT + TABLE_INDEX_BITS +: DIR_INDEX_BITS];

  always_comb begin
    cmd.op          = tlpt_op_e'(req_i.mode);
    cmd.phys_frame  = req_i.phys_frame;
    cmd.table_frame = req_i.table_frame;
  end

  assign push_data_o = {dir_idx, tbl_idx, cmd};

endmodule

>>> hw/rtl/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back
// Executes queued commands against the directory and page entry memories.
// ----------------------------------------------------------------------------
module tlpt_back import tlpt_pkg::*; #(
  parameter int unsigned DIR_INDEX_BITS   = 10,
  parameter int unsigned TABLE_INDEX_BITS = 10,
  localparam int unsigned QW = DIR_INDEX_BITS + TABLE_INDEX_BITS + $bits(tlpt_cmd_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  logic [QW-1:0] pop_data_i,
  output logic          pop_ready_o,
  output logic          init_done_o,
  tlpt_rsp_if.source    rsp_o
);

  localparam int unsigned DIR_SIZE = 1 << DIR_INDEX_BITS;
  localparam int unsigned PG_AW    = DIR_INDEX_BITS + TABLE_INDEX_BITS;
  localparam int unsigned PG_SIZE  = 1 << PG_AW;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [ENTRY_W-1:0] dir_mem [DIR_SIZE];
  logic [ENTRY_W-1:0] pg_mem  [PG_SIZE];

  logic [1:0]                  state_q, state_d;
  logic [DIR_INDEX_BITS-1:0]   init_q, init_d;
  logic [TABLE_INDEX_BITS-1:0] clr_q, clr_d;
  logic [DIR_INDEX_BITS-1:0]   di_q, head_di;
  logic [TABLE_INDEX_BITS-1:0] ti_q, head_ti;
  tlpt_cmd_t                   cmd_q, head_cmd;
  logic [ENTRY_W-1:0]          dir_rd_q, pg_rd_q;

  logic                        dir_we;
  logic [DIR_INDEX_BITS-1:0]   dir_waddr;
  logic [ENTRY_W-1:0]          dir_wdata;
  logic                        pg_we;
  logic [PG_AW-1:0]            pg_waddr;
  logic [ENTRY_W-1:0]          pg_wdata;
  logic [ENTRY_W-1:0]          new_pg_entry;

  logic                        out_free, pop, finish;
  logic                        rsp_valid_q, rsp_valid_d;
  tlpt_status_e                rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]           rsp_addr_q, rsp_addr_d;
  logic [FLAG_W-1:0]           rsp_flags_q, rsp_flags_d;

  assign {head_di, head_ti, head_cmd} = pop_data_i;

  // a command only starts once the output register can take its result
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign pop         = (state_q == S_IDLE) && pop_valid_i && out_free;
  assign pop_ready_o = pop;
  assign init_done_o = (state_q != S_INIT);

  assign new_pg_entry = {cmd_q.phys_frame, NEW_FLAGS};

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    clr_d        = clr_q;
    dir_we       = 1'b0;
    dir_waddr    = di_q;
    dir_wdata    = {cmd_q.table_frame, NEW_FLAGS};
    pg_we        = 1'b0;
    pg_waddr     = {di_q, ti_q};
    pg_wdata     = '0;
    finish       = 1'b0;
    rsp_status_d = ST_OK;
    rsp_addr_d   = '0;
    rsp_flags_d  = '0;
    case (state_q)
      S_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = init_q;
        dir_wdata = '0;
        init_d    = init_q + 1'b1;
        if (init_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q.op)
          OP_LOOKUP, OP_UNMAP: begin
            finish = 1'b1;
            if (!dir_rd_q[0]) begin
              rsp_status_d = ST_NO_TABLE;
            end else if (!pg_rd_q[0]) begin
              rsp_status_d = ST_NO_PAGE;
            end else if (cmd_q.op == OP_LOOKUP) begin
              rsp_addr_d  = {pg_rd_q[ENTRY_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
              rsp_flags_d = pg_rd_q[FLAG_W-1:0];
            end else begin
              pg_we = 1'b1;
            end
          end
          OP_MAP: begin
            if (dir_rd_q[0]) begin
              finish = 1'b1;
              if (pg_rd_q[0]) begin
                rsp_status_d = ST_MAPPED;
              end else begin
                pg_we    = 1'b1;
                pg_wdata = new_pg_entry;
              end
            end else begin
              // new table: write the directory entry, then sweep the table
              dir_we  = 1'b1;
              clr_d   = '0;
              state_d = S_CLR;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        // the mapped slot gets its entry during the sweep itself
        pg_we    = 1'b1;
        pg_waddr = {di_q, clr_q};
        pg_wdata = (clr_q == ti_q) ? new_pg_entry : '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) begin
          finish  = 1'b1;
          clr_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (finish) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      di_q  <= head_di;
      ti_q  <= head_ti;
      cmd_q <= head_cmd;
    end
    if (finish) begin
      rsp_status_q <= rsp_status_d;
      rsp_addr_q   <= rsp_addr_d;
      rsp_flags_q  <= rsp_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (pop) begin
      dir_rd_q <= dir_mem[head_di];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      pg_mem[pg_waddr] <= pg_wdata;
    end
    if (pop) begin
      pg_rd_q <= pg_mem[{head_di, head_ti}];
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.phys_addr   = rsp_addr_q;
  assign rsp_o.entry_flags = rsp_flags_q;

endmodule

>>> hw/rtl/tlpt_checker.sv
// ----------------------------------------------------------------------------
// tlpt_checker
// Port-level checks of the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module tlpt_checker import tlpt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic [ADDR_W-1:0] rsp_phys_addr_i,
  input logic [FLAG_W-1:0] rsp_flags_i
);

  // requests accepted whose result is not yet taken
  logic [2:0] pending_q, pending_d;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i & req_ready_i;
  assign rsp_acc = rsp_valid_i & rsp_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (req_acc && !rsp_acc) begin
      pending_d = pending_q + 1'b1;
    end else if (rsp_acc && !req_acc) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_phys_addr_i) && $stable(rsp_flags_i))
    else $error("response changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_phys_addr_i == '0) && (rsp_flags_i == '0))
    else $error("failed request returned address or flags");

  a_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_phys_addr_i[PAGE_SHIFT-1:0] == '0))
    else $error("physical address not page aligned");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pending_q != '0))
    else $error("response without an outstanding request");

endmodule

bind two_level_page_table_engine_unit tlpt_checker u_tlpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_phys_addr_i(rsp_o.phys_addr),
  .rsp_flags_i    (rsp_o.entry_flags)
);
